>>> sv/height_map_gradient_core_assert.svh
// Assertion macros shared by the gradient core modules.
`ifndef HEIGHT_MAP_GRADIENT_CORE_ASSERT_SVH
`define HEIGHT_MAP_GRADIENT_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HMG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hmg assertion failed");

// Next-cycle implication, checked out of reset.
`define HMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hmg assertion failed");

`endif

>>> sv/hmg_pkg.sv
package hmg_pkg;

  localparam int PIX_W    = 8;
  localparam int DIM_W    = 11;
  localparam int POS_W    = 10;
  localparam int GRAD_W   = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic signed [GRAD_W-1:0] across;
    logic signed [GRAD_W-1:0] down;
    logic                     frame_end;
  } res_t;

  // up to two results per transaction; b is only ever set together with a
  typedef struct packed {
    logic a;
    logic b;
  } push_t;

endpackage

>>> sv/height_map_gradient_core.sv
// Channel   Handshake                  Payload
// in_       in_valid / in_stall        in_pixel_red
// out_      out_valid / out_stall      out_row, out_col, out_grad_across,
//                                      out_grad_down, out_frame_end
// cfg_      cfg_wr_en, cfg_index       cfg_wdata
//
// One pixel per cycle while in_stall is low: a pixel is read against both line
// stores on acceptance and its results are formed from the registered read data.
// Results trail the input by one row and one column; the last column of a row
// yields two results, held in a four-entry output queue.
// Reset (synchronous, rst_n low) clears counters, taps and the queue; the line
// stores are not cleared. A register write restarts the stream at row 0.
// in_stall rises only while the output queue cannot take two more results.

`include "height_map_gradient_core_assert.svh"

module height_map_gradient_core import hmg_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIX_W-1:0]         in_pixel_red,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [POS_W-1:0]         out_row,
  output logic [POS_W-1:0]         out_col,
  output logic signed [GRAD_W-1:0] out_grad_across,
  output logic signed [GRAD_W-1:0] out_grad_down,
  output logic                     out_frame_end,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WDW = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int HDW = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [WDW-1:0]   w_raw, w_eff;
  logic [HDW-1:0]   h_raw, h_eff;
  logic [CW-1:0]    w_last;
  logic [RW-1:0]    h_last;

  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic [RW-1:0]    row_cnt_r, row_cnt_nxt;

  logic             s1_vld_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;

  logic [PIX_W-1:0] tap0_r, tap1_r;
  logic             primed_r;
  logic signed [GRAD_W-1:0] held_down_r;

  logic             in_acc;
  logic             adv;
  logic             room;
  logic [PIX_W-1:0] mid, above_raw, above, below, left;
  logic [RW-1:0]    orow;
  logic signed [GRAD_W-1:0] down_now;
  push_t            push;
  res_t             res_a, res_b, head;

  // dimension saturation
  always_comb begin
    w_raw = WDW'(width_r);
    h_raw = HDW'(height_r);
    if (w_raw < WDW'(2)) begin
      w_eff = WDW'(2);
    end else if (w_raw > WDW'(MAX_WIDTH)) begin
      w_eff = WDW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < HDW'(2)) begin
      h_eff = HDW'(2);
    end else if (h_raw > HDW'(MAX_HEIGHT)) begin
      h_eff = HDW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    w_last = CW'(w_eff - WDW'(1));
    h_last = RW'(h_eff - HDW'(1));
  end

  assign adv      = s1_vld_r && room;
  assign in_stall = s1_vld_r && !room;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    if (col_cnt_r == w_last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_cnt_r == h_last) ? '0 : row_cnt_r + RW'(1);
    end else begin
      col_cnt_nxt = col_cnt_r + CW'(1);
      row_cnt_nxt = row_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1024);
      height_r <= DIM_W'(1024);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      primed_r    <= 1'b0;
      held_down_r <= '0;
      tap0_r      <= '0;
      tap1_r      <= '0;
    end else begin
      if (in_acc) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
        s1_vld_r  <= 1'b1;
      end else if (adv) begin
        s1_vld_r  <= 1'b0;
      end
      if (adv) begin
        tap0_r      <= mid;
        tap1_r      <= tap0_r;
        held_down_r <= down_now;
        if (s1_col_r == w_last) begin
          primed_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r  <= in_pixel_red;
      s1_col_r <= col_cnt_r;
      s1_row_r <= row_cnt_r;
    end
  end

  hmg_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (col_cnt_r),
    .wr_en    (adv),
    .wr_addr  (s1_col_r),
    .wr_prev  (s1_px_r),
    .wr_older (mid),
    .rd_prev  (mid),
    .rd_older (above_raw)
  );

  // vertical difference with edge clamping
  always_comb begin
    if (s1_row_r == '0) begin
      orow  = h_last;
      below = mid;
      above = above_raw;
    end else begin
      orow  = s1_row_r - RW'(1);
      below = s1_px_r;
      above = (orow == '0) ? mid : above_raw;
    end
    down_now = $signed({1'b0, below}) - $signed({1'b0, above});
    left     = (s1_col_r == CW'(1)) ? tap0_r : tap1_r;
  end

  always_comb begin
    push.a = adv && primed_r && (s1_col_r != '0);
    push.b = adv && primed_r && (s1_col_r == w_last);

    res_a.row       = POS_W'(orow);
    res_a.col       = POS_W'(s1_col_r - CW'(1));
    res_a.across    = $signed({1'b0, mid}) - $signed({1'b0, left});
    res_a.down      = held_down_r;
    res_a.frame_end = 1'b0;

    res_b.row       = POS_W'(orow);
    res_b.col       = POS_W'(s1_col_r);
    res_b.across    = $signed({1'b0, mid}) - $signed({1'b0, tap0_r});
    res_b.down      = down_now;
    res_b.frame_end = (orow == h_last);
  end

  hmg_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res_a    (res_a),
    .res_b    (res_b),
    .room     (room),
    .head_vld (out_valid),
    .head     (head),
    .pop      (!out_stall)
  );

  assign out_row         = head.row;
  assign out_col         = head.col;
  assign out_grad_across = head.across;
  assign out_grad_down   = head.down;
  assign out_frame_end   = head.frame_end;

  `HMG_ASSERT_IMPL(a_b_with_a, clk, rst_n, push.b, push.a)
  `HMG_ASSERT_IMPL(a_stall_only_busy, clk, rst_n, in_stall, s1_vld_r)
  `HMG_ASSERT_NEXT(a_col_wrap, clk, rst_n, in_acc && (col_cnt_r == w_last), col_cnt_r == '0)

endmodule

>>> sv/hmg_line_store.sv
module hmg_line_store import hmg_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [PIX_W-1:0]         wr_prev,
  input  logic [PIX_W-1:0]         wr_older,
  output logic [PIX_W-1:0]         rd_prev,
  output logic [PIX_W-1:0]         rd_older
);

  logic [PIX_W-1:0] prev_mem  [DEPTH];
  logic [PIX_W-1:0] older_mem [DEPTH];
  logic [PIX_W-1:0] rd_prev_r;
  logic [PIX_W-1:0] rd_older_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_addr]  <= wr_prev;
      older_mem[wr_addr] <= wr_older;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_prev_r  <= prev_mem[rd_addr];
      rd_older_r <= older_mem[rd_addr];
    end
  end

  assign rd_prev  = rd_prev_r;
  assign rd_older = rd_older_r;

endmodule

>>> sv/hmg_out_fifo.sv
`include "height_map_gradient_core_assert.svh"

module hmg_out_fifo import hmg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  res_t  res_a,
  input  res_t  res_b,
  output logic  room,
  output logic  head_vld,
  output res_t  head,
  input  logic  pop
);

  res_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, wp_nxt;
  logic [FIFO_PTR_W-1:0] rp_r, rp_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]            npush;
  logic                  do_pop;

  assign npush  = {1'b0, push.a} + {1'b0, push.b};
  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wp_nxt  = wp_r + FIFO_PTR_W'(npush);
    rp_nxt  = rp_r + FIFO_PTR_W'(do_pop);
    cnt_nxt = cnt_r + FIFO_CNT_W'(npush) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.a) begin
      mem_r[wp_r] <= res_a;
    end
    if (push.b) begin
      mem_r[wp_r + FIFO_PTR_W'(1)] <= res_b;
    end
  end

  assign room     = cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign head_vld = cnt_r != '0;
  assign head     = mem_r[rp_r];

  `HMG_ASSERT_IMPL(a_fifo_bound, clk, rst_n, 1'b1, cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
  `HMG_ASSERT_IMPL(a_fifo_push_room, clk, rst_n, push.a, room)

endmodule

>>> tb/sv/tb_height_map_gradient_core.sv
`timescale 1ns / 100ps

module tb_height_map_gradient_core;
  import hmg_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int RANDOM_ITEMS   = 88;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 40;

  typedef enum logic {STEP_PIXEL, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     value;
    logic                 typed;
    logic [1:0]           n_typed;
    res_t                 res_a;
    res_t                 res_b;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [PIX_W-1:0] in_pixel_red;
  logic out_valid;
  logic out_stall;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic signed [GRAD_W-1:0] out_grad_across;
  logic signed [GRAD_W-1:0] out_grad_down;
  logic out_frame_end;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  // gradient predictor state
  logic [DIM_W-1:0] width_reg = 11'd1024;
  logic [DIM_W-1:0] height_reg = 11'd1024;
  bit [PIX_W-1:0] older_line [MAX_WIDTH];
  bit [PIX_W-1:0] prev_line [MAX_WIDTH];
  bit [PIX_W-1:0] taps [3];
  int unsigned col_pos;
  int unsigned row_pos;
  bit primed;
  int held_down;

  res_t gradient_q [$];
  int mismatch_count;
  int quiet_cycles;
  bit no_idle;

  always #(CLK_PERIOD / 2) clk = ~clk;

  height_map_gradient_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_red    (in_pixel_red),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_grad_across (out_grad_across),
    .out_grad_down   (out_grad_down),
    .out_frame_end   (out_frame_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  function automatic int pick_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned cap);
    if (v < 2) return 2;
    if (v > cap) return cap;
    return 32'(v);
  endfunction

  function automatic res_t make_grad(input int row, input int col, input int across,
                                     input int down, input bit fe);
    res_t r;
    r.row       = POS_W'(row);
    r.col       = POS_W'(col);
    r.across    = GRAD_W'(across);
    r.down      = GRAD_W'(down);
    r.frame_end = fe;
    return r;
  endfunction

  function automatic step_t pixel_step(input logic [PIX_W-1:0] v);
    step_t s;
    s = '0;
    s.kind  = STEP_PIXEL;
    s.value = DIM_W'(v);
    return s;
  endfunction

  function automatic step_t typed_step(input logic [PIX_W-1:0] v, input int n,
                                       input res_t a, input res_t b);
    step_t s;
    s = pixel_step(v);
    s.typed   = 1'b1;
    s.n_typed = n[1:0];
    s.res_a   = a;
    s.res_b   = b;
    return s;
  endfunction

  function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [DIM_W-1:0] v);
    step_t s;
    s = '0;
    s.kind  = STEP_CFG;
    s.idx   = idx;
    s.value = v;
    return s;
  endfunction

  // Central differences (one-sided at the image edges) of the pixel one row and one column behind the input.
  function automatic void predict_gradients(input logic [PIX_W-1:0] px);
    int unsigned w, h, k, r, orow;
    int mid, above, below, down_now, left;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    k = col_pos;
    r = row_pos;
    if (k >= w) k = w - 1;
    if (r >= h) r = h - 1;
    mid   = int'(prev_line[k]);
    above = int'(older_line[k]);
    if (r == 0) begin
      orow  = h - 1;
      below = mid;
    end else begin
      orow  = r - 1;
      below = int'(px);
      if (orow == 0) above = mid;
    end
    down_now = below - above;
    older_line[k] = PIX_W'(mid);
    prev_line[k]  = px;
    taps[2] = taps[1];
    taps[1] = taps[0];
    taps[0] = PIX_W'(mid);
    if (primed && k >= 1) begin
      left = (k == 1) ? int'(taps[1]) : int'(taps[2]);
      gradient_q.push_back(make_grad(orow, k - 1, int'(taps[0]) - left, held_down, 1'b0));
    end
    if (primed && k == w - 1)
      gradient_q.push_back(make_grad(orow, k, int'(taps[0]) - int'(taps[1]), down_now,
                                     orow == h - 1));
    held_down = down_now;
    if (k + 1 >= w) begin
      col_pos = 0;
      primed  = 1'b1;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = k + 1;
      row_pos = r;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // entered and left at a falling edge
  task automatic send_pixel(input step_t st);
    int gap;
    int q_depth;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_pixel_red <= st.value[PIX_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    q_depth = gradient_q.size();
    predict_gradients(st.value[PIX_W-1:0]);
    if (st.typed) begin
      while (gradient_q.size() > q_depth) void'(gradient_q.pop_back());
      if (st.n_typed > 0) gradient_q.push_back(st.res_a);
      if (st.n_typed > 1) gradient_q.push_back(st.res_b);
    end
    @(negedge clk);
  endtask

  // only while idle: the last pixel may still be in flight without a result
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    in_valid <= 1'b0;
    while (gradient_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = v;
    else height_reg = v;
    col_pos   = 0;
    row_pos   = 0;
    primed    = 1'b0;
    held_down = 0;
    taps      = '{default: '0};
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (gradient_q.size() == 0) begin
        report_mismatch("result with nothing pending, row", out_row, -1);
      end else begin
        want = gradient_q.pop_front();
        if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
        if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
        if (out_grad_across !== want.across)
          report_mismatch("out_grad_across", out_grad_across, want.across);
        if (out_grad_down !== want.down)
          report_mismatch("out_grad_down", out_grad_down, want.down);
        if (out_frame_end !== want.frame_end)
          report_mismatch("out_frame_end", out_frame_end, want.frame_end);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_height_map_gradient_core: FAIL");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = pick_wait();
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin
    step_t directed_steps [$];
    logic [DIM_W-1:0] w_raw, h_raw;
    int unsigned w, h, rows, n, random_items;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_pixel_red = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_IMAGE_WIDTH;
    cfg_wdata    = '0;
    no_idle      = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    directed_steps = '{
      // reset size: first row not complete, nothing comes out
      typed_step(8'h00, 0, '0, '0),
      typed_step(8'hFF, 0, '0, '0),
      cfg_step(CFG_IMAGE_WIDTH, 11'd2),
      cfg_step(CFG_IMAGE_HEIGHT, 11'd2),
      // 2x2 image, opposite extremes
      typed_step(8'd0, 0, '0, '0),
      typed_step(8'd255, 0, '0, '0),
      typed_step(8'd255, 0, '0, '0),
      typed_step(8'd0, 2, make_grad(0, 0, 255, 255, 1'b0),
                 make_grad(0, 1, 255, -255, 1'b0)),
      typed_step(8'd0, 0, '0, '0),
      typed_step(8'd128, 2, make_grad(1, 0, -255, 255, 1'b0),
                 make_grad(1, 1, -255, -255, 1'b1)),
      // out-of-range sizes saturate to 2
      cfg_step(CFG_IMAGE_WIDTH, 11'd0),
      cfg_step(CFG_IMAGE_HEIGHT, 11'd1),
      pixel_step(8'h01), pixel_step(8'h80), pixel_step(8'h7F),
      pixel_step(8'hFE), pixel_step(8'h55), pixel_step(8'hAA),
      cfg_step(CFG_IMAGE_WIDTH, 11'd3),
      cfg_step(CFG_IMAGE_HEIGHT, 11'd3),
      pixel_step(8'd10), pixel_step(8'd20), pixel_step(8'd30),
      pixel_step(8'd255), pixel_step(8'd0), pixel_step(8'd255),
      pixel_step(8'd0), pixel_step(8'd255), pixel_step(8'd0)
    };

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG)
        write_reg(directed_steps[i].idx, directed_steps[i].value);
      else
        send_pixel(directed_steps[i]);
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w_raw = DIM_W'($urandom_range(0, 1));
        1: w_raw = DIM_W'(2);
        default: w_raw = DIM_W'($urandom_range(3, 7));
      endcase
      case ($urandom_range(0, 9))
        0: h_raw = DIM_W'($urandom_range(0, 1));
        1: h_raw = DIM_W'($urandom_range(1025, 2047));
        default: h_raw = DIM_W'($urandom_range(2, 5));
      endcase
      write_reg(CFG_IMAGE_WIDTH, w_raw);
      write_reg(CFG_IMAGE_HEIGHT, h_raw);
      w = eff_dim(w_raw, MAX_WIDTH);
      h = eff_dim(h_raw, MAX_HEIGHT);
      rows = (h > 8) ? $urandom_range(2, 6) : h * $urandom_range(1, 2) + 1;
      n = rows * w + $urandom_range(0, w - 1);
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (n) send_pixel(pixel_step(pick_pixel()));
      random_items += n;
    end

    in_valid <= 1'b0;
    while (gradient_q.size() != 0) @(posedge clk);
    repeat (3 * DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("tb_height_map_gradient_core: PASS");
    else $display("tb_height_map_gradient_core: FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/hmg_pkg.sv
sv/hmg_line_store.sv
sv/hmg_out_fifo.sv
sv/height_map_gradient_core.sv
tb/sv/tb_height_map_gradient_core.sv
